// ===== rtl/dc2d_pkg.sv =====
// shared types and constants for the 2d density clustering block
package dc2d_pkg;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned EpsBits = 36;
  localparam int unsigned MinBits = 7;
  localparam int unsigned IdBits = 6;
  // label entry: assigned flag on top of the cluster number
  localparam int unsigned LabBits = IdBits + 1;
  localparam int unsigned CfgAddrBits = 1;
  localparam logic [CfgAddrBits-1:0] CfgEps = 1'b0;
  localparam logic [CfgAddrBits-1:0] CfgMin = 1'b1;

  typedef struct packed {
    logic [IdBits-1:0] point_index;
    logic [IdBits-1:0] cluster_id;
    logic              is_noise;
    logic              last_label;
  } label_t;
endpackage

// ===== rtl/dc2d_if.sv =====
// valid/ready channel interfaces for points and labels
interface dc2d_point_if;
  logic                           valid;
  logic                           ready;
  logic [dc2d_pkg::CoordBits-1:0] point_x;
  logic [dc2d_pkg::CoordBits-1:0] point_y;
  logic                           last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface dc2d_label_if;
  logic                        valid;
  logic                        ready;
  logic [dc2d_pkg::IdBits-1:0] point_index;
  logic [dc2d_pkg::IdBits-1:0] cluster_id;
  logic                        is_noise;
  logic                        last_label;
  modport source (output valid, point_index, cluster_id, is_noise, last_label, input ready);
  modport sink (input valid, point_index, cluster_id, is_noise, last_label, output ready);
endinterface

// ===== rtl/density_cluster_2d_core.sv =====
// channel        | dir | payload
// point_in       | in  | point_x, point_y, last_point
// label_out      | out | point_index, cluster_id, is_noise, last_label
// cfg_we_i       | in  | cfg_idx_i, cfg_data_i
// loading takes one point per cycle; point_in is ready only while loading.
// clustering: clear the labels, then per seed a label check, a core scan and,
// for core points, a claim scan; each queued point is popped and fetched before
// its own scans. the pace is set by the single coordinate read port feeding one
// distance unit. labels leave via SOut and SOutW; the output register holds
// a label while label_out is stalled. reset clears control state and eps_q and
// sets min_q to 2.
module density_cluster_2d_core import dc2d_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgAddrBits-1:0] cfg_idx_i,
  input  logic [EpsBits-1:0]     cfg_data_i,
  dc2d_point_if.sink             point_in,
  dc2d_label_if.source           label_out
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = AW + 1;
  localparam logic [3:0] SLoad = 4'd0, SClr = 4'd1, SSeed = 4'd2, SSeedW = 4'd3,
    SCore = 4'd4, SCoreW = 4'd5, SClaim = 4'd6, SPop = 4'd7, SPopW = 4'd8,
    SFetch = 4'd9, SFetchW = 4'd10, SNext = 4'd11, SOut = 4'd12, SOutW = 4'd13;

  logic [EpsBits-1:0] eps_q;
  logic [MinBits-1:0] min_q;
  logic [3:0] st_q, st_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] j_q, j_d;         // scan index, issue side
  logic [AW-1:0] seed_q, seed_d;
  logic [AW-1:0] p_q, p_d;         // point under test
  logic [CW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IdBits-1:0] clus_q, clus_d;
  logic [1:0] vpipe_q;             // valid of scan pipeline
  logic [AW-1:0] jp1_q, jp2_q;

  logic [CoordBits-1:0] xm [MAX_POINTS];
  logic [CoordBits-1:0] ym [MAX_POINTS];
  logic [LabBits-1:0] lm [MAX_POINTS];  // top bit assigned, low bits cluster
  logic [AW-1:0] qm [MAX_POINTS];
  logic [CoordBits-1:0] bx_q, by_q, px_q, py_q, px_d, py_d;
  logic [LabBits-1:0] lab_q, lab_c_q;
  logic [AW-1:0] qrd_q;

  logic ld_fire, near, scanning, scan_fire, claimed;
  logic lwe;
  logic [AW-1:0] lwa;
  logic [LabBits-1:0] lwd;
  logic qwe;
  logic [AW-1:0] lra, qra, crd;
  logic ovalid_q;
  label_t ol_q;

  assign ld_fire = point_in.valid && point_in.ready;
  assign point_in.ready = (st_q == SLoad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
      min_q <= MinBits'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEps: eps_q <= cfg_data_i;
        CfgMin: min_q <= cfg_data_i[MinBits-1:0];
        default: ;
      endcase
    end
  end

  // coordinate memories: write on load, one read port
  always_ff @(posedge clk_i) begin
    if (ld_fire && n_q < CW'(MAX_POINTS)) begin
      xm[n_q[AW-1:0]] <= point_in.point_x;
      ym[n_q[AW-1:0]] <= point_in.point_y;
    end
    bx_q <= xm[crd];
    by_q <= ym[crd];
  end

  // label memory, read data registered once more (lab_c_q) to line up with the compare
  always_ff @(posedge clk_i) begin
    if (lwe) lm[lwa] <= lwd;
    lab_q <= lm[lra];
    lab_c_q <= lab_q;
  end

  // breadth-first work list
  always_ff @(posedge clk_i) begin
    if (qwe) qm[tail_q[AW-1:0]] <= jp2_q;
    qrd_q <= qm[qra];
  end

  // pipeline: issue j -> mem read -> square reg -> compare
  dc2d_dist u_dist (
    .clk_i, .ax_i(px_q), .ay_i(py_q), .bx_i(bx_q), .by_i(by_q),
    .eps_i(eps_q), .near_o(near)
  );

  assign scanning = (st_q == SCore) || (st_q == SClaim);
  assign scan_fire = scanning && (j_q < n_q);
  assign qra = head_q[AW-1:0];
  assign claimed = (st_q == SClaim) && vpipe_q[1] && near && !lab_c_q[IdBits];

  always_ff @(posedge clk_i) begin
    jp1_q <= j_q[AW-1:0];
    jp2_q <= jp1_q;
    px_q <= px_d;
    py_q <= py_d;
  end

  always_comb begin
    st_d = st_q; n_d = n_q; j_d = j_q; seed_d = seed_q; p_d = p_q;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q; clus_d = clus_q;
    px_d = px_q; py_d = py_q;
    lwe = 1'b0; lwa = jp2_q; lwd = {1'b1, clus_q}; qwe = 1'b0;
    crd = j_q[AW-1:0];
    lra = j_q[AW-1:0];
    if (claimed) begin
      lwe = 1'b1;
      if (tail_q < CW'(MAX_POINTS)) begin
        qwe = 1'b1;
        tail_d = tail_q + 1'b1;
      end
    end
    if (st_q == SCore && vpipe_q[1] && near) cnt_d = cnt_q + 1'b1;
    if (scan_fire) j_d = j_q + 1'b1;
    case (st_q)
      SLoad: begin
        if (ld_fire) begin
          if (n_q < CW'(MAX_POINTS)) n_d = n_q + 1'b1;
          if (point_in.last_point) begin
            st_d = SClr;
            j_d = '0;
          end
        end
      end
      SClr: begin
        lwe = 1'b1; lwa = j_q[AW-1:0]; lwd = '0;
        if (j_q + 1'b1 >= n_q) begin
          st_d = SSeed; seed_d = '0; clus_d = '0;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      SSeed: begin
        lra = seed_q; crd = seed_q; p_d = seed_q;
        st_d = SSeedW;
      end
      SSeedW: begin
        // seed already in a cluster: skip it
        if (lab_q[IdBits]) begin
          st_d = SNext;
        end else begin
          px_d = bx_q; py_d = by_q;
          head_d = '0; tail_d = '0; j_d = '0; cnt_d = '0;
          st_d = SCore;
        end
      end
      SCore: if (!scan_fire && vpipe_q == '0) st_d = SCoreW;
      SCoreW: begin
        if (MinBits'(cnt_q) >= min_q) begin
          // head still zero only while testing the seed itself
          if (head_q == '0) begin
            lwe = 1'b1; lwa = p_q;
          end
          j_d = '0;
          st_d = SClaim;
        end else if (head_q == '0) begin
          st_d = SNext;
        end else begin
          st_d = SPop;
        end
      end
      SClaim: if (!scan_fire && vpipe_q == '0) st_d = SPop;
      SPop: begin
        if (head_q < tail_q) begin
          st_d = SPopW;
        end else begin
          clus_d = clus_q + 1'b1;
          st_d = SNext;
        end
      end
      SPopW: begin
        p_d = qrd_q; head_d = head_q + 1'b1;
        st_d = SFetch;
      end
      SFetch: begin
        crd = p_q;
        st_d = SFetchW;
      end
      SFetchW: begin
        px_d = bx_q; py_d = by_q; j_d = '0; cnt_d = '0;
        st_d = SCore;
      end
      SNext: begin
        if (CW'(seed_q) + 1'b1 >= n_q) begin
          st_d = SOut; j_d = '0;
        end else begin
          seed_d = seed_q + 1'b1; st_d = SSeed;
        end
      end
      SOut: if (!ovalid_q || label_out.ready) st_d = SOutW;
      SOutW: begin
        if (j_q + 1'b1 >= n_q) begin
          st_d = SLoad; n_d = '0;
        end else begin
          j_d = j_q + 1'b1; st_d = SOut;
        end
      end
      default: st_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SLoad; n_q <= '0; j_q <= '0; seed_q <= '0; p_q <= '0;
      head_q <= '0; tail_q <= '0; cnt_q <= '0; clus_q <= '0; vpipe_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; j_q <= j_d; seed_q <= seed_d; p_q <= p_d;
      head_q <= head_d; tail_q <= tail_d; cnt_q <= cnt_d; clus_q <= clus_d;
      vpipe_q <= {vpipe_q[0], scan_fire};
      if (st_q == SOutW) ovalid_q <= 1'b1;
      else if (label_out.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SOutW) begin
      ol_q.point_index <= IdBits'(j_q);
      ol_q.is_noise <= !lab_q[IdBits];
      ol_q.cluster_id <= lab_q[IdBits] ? lab_q[IdBits-1:0] : '0;
      ol_q.last_label <= (j_q + 1'b1 == n_q);
    end
  end

  assign label_out.valid = ovalid_q;
  assign label_out.point_index = ol_q.point_index;
  assign label_out.cluster_id = ol_q.cluster_id;
  assign label_out.is_noise = ol_q.is_noise;
  assign label_out.last_label = ol_q.last_label;

  a_busy_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != SLoad |-> n_q != '0) else $error("empty set in flight");
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue underflow");
  a_tail_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CW'(MAX_POINTS)) else $error("queue overflow");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_POINTS)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !label_out.ready |=> ovalid_q && $stable(ol_q)) else $error("label dropped");
endmodule

// ===== rtl/dc2d_dist.sv =====
// registered squared-distance test between two points
module dc2d_dist import dc2d_pkg::*; (
  input  logic                 clk_i,
  input  logic [CoordBits-1:0] ax_i,
  input  logic [CoordBits-1:0] ay_i,
  input  logic [CoordBits-1:0] bx_i,
  input  logic [CoordBits-1:0] by_i,
  input  logic [EpsBits-1:0]   eps_i,
  output logic                 near_o
);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned CmpW = ((SW + 1) > EpsBits) ? (SW + 1) : EpsBits;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] adx, ady;
  logic [SW-1:0] sx_q, sy_q;
  logic [SW:0] sum;
  logic [CmpW-1:0] s_ext, e_ext;

  assign dx = $signed({ax_i[CoordBits-1], ax_i}) - $signed({bx_i[CoordBits-1], bx_i});
  assign dy = $signed({ay_i[CoordBits-1], ay_i}) - $signed({by_i[CoordBits-1], by_i});
  assign adx = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
  assign ady = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);

  always_ff @(posedge clk_i) begin
    sx_q <= {{DW{1'b0}}, adx} * {{DW{1'b0}}, adx};
    sy_q <= {{DW{1'b0}}, ady} * {{DW{1'b0}}, ady};
  end

  assign sum = {1'b0, sx_q} + {1'b0, sy_q};
  assign s_ext = CmpW'(sum);
  assign e_ext = CmpW'(eps_i);
  assign near_o = s_ext < e_ext;
endmodule

// ===== dv/density_cluster_2d_core_tb.sv =====
// testbench for the 2d density clustering core: sets of points in, one label per stored point out
`timescale 1ns / 100ps

module density_cluster_2d_core_tb;
  import dc2d_pkg::*;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned IdleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgAddrBits-1:0] cfg_idx_i;
  logic [EpsBits-1:0] cfg_data_i;

  dc2d_point_if point_in ();
  dc2d_label_if label_out ();

  density_cluster_2d_core #(
    .MAX_POINTS(NumSlots)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .point_in(point_in),
    .label_out(label_out)
  );

  // shadow copy of the block's state
  logic [EpsBits-1:0] radius_sq;
  logic [MinBits-1:0] core_count;
  logic signed [15:0] xs[NumSlots];
  logic signed [15:0] ys[NumSlots];
  int unsigned n_stored;

  label_t expected_labels[$];
  int unsigned n_mismatch;
  int unsigned n_labels;
  int unsigned n_points;
  int unsigned n_sets;
  int unsigned idle_cycles;
  int unsigned hold_off;
  bit rx_gaps;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_neighbor(int unsigned a, int unsigned b);
    longint signed dx;
    longint signed dy;
    longint unsigned dist_sq;
    dx = longint'(xs[a]) - longint'(xs[b]);
    dy = longint'(ys[a]) - longint'(ys[b]);
    dist_sq = longint'(dx * dx) + longint'(dy * dy);
    return dist_sq < {28'd0, radius_sq};
  endfunction

  function automatic bit is_core_point(int unsigned p);
    int unsigned cnt;
    cnt = 0;
    for (int unsigned j = 0; j < n_stored; j++) begin
      if (is_neighbor(p, j)) cnt++;
    end
    return cnt >= core_count;
  endfunction

  // breadth-first cluster growth over the stored set, labels queued in index order
  task automatic predict_labels();
    bit assigned[NumSlots];
    logic [IdBits-1:0] cid[NumSlots];
    int unsigned frontier[$];
    int unsigned next_id;
    int unsigned p;
    label_t lab;
    next_id = 0;
    for (int unsigned i = 0; i < NumSlots; i++) begin
      assigned[i] = 1'b0;
      cid[i] = '0;
    end
    for (int unsigned i = 0; i < n_stored; i++) begin
      if (assigned[i] || !is_core_point(i)) continue;
      assigned[i] = 1'b1;
      cid[i] = next_id[IdBits-1:0];
      frontier = {i};
      while (frontier.size() > 0) begin
        p = frontier.pop_front();
        if (p != i && !is_core_point(p)) continue;
        for (int unsigned j = 0; j < n_stored; j++) begin
          if (!assigned[j] && is_neighbor(p, j)) begin
            assigned[j] = 1'b1;
            cid[j] = next_id[IdBits-1:0];
            frontier = {frontier, j};
          end
        end
      end
      next_id = (next_id + 1) & 7'h7f;
    end
    for (int unsigned i = 0; i < n_stored; i++) begin
      lab.point_index = i[IdBits-1:0];
      lab.cluster_id = assigned[i] ? cid[i] : '0;
      lab.is_noise = !assigned[i];
      lab.last_label = (i + 1 == n_stored);
      expected_labels = {expected_labels, lab};
    end
  endtask

  task automatic send_point(logic signed [15:0] px, logic signed [15:0] py, bit last);
    int unsigned gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      point_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_in.valid <= 1'b1;
    point_in.point_x <= px;
    point_in.point_y <= py;
    point_in.last_point <= last;
    do @(posedge clk_i); while (!point_in.ready);
    n_points++;
    if (n_stored < NumSlots) begin
      xs[n_stored] = px;
      ys[n_stored] = py;
      n_stored++;
    end
    if (last) begin
      predict_labels();
      n_stored = 0;
      n_sets++;
    end
  endtask

  task automatic wait_drained();
    point_in.valid <= 1'b0;
    while (expected_labels.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrBits-1:0] idx, logic [EpsBits-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgEps) radius_sq = val;
    else core_count = val[MinBits-1:0];
  endtask

  // random cloud: a few tight blobs plus scattered points
  task automatic send_cloud(int unsigned n, int unsigned spread);
    int signed cx;
    int signed cy;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 5 == 0) begin
        cx = $urandom_range(0, 60000) - 30000;
        cy = $urandom_range(0, 60000) - 30000;
      end
      if ($urandom_range(0, 5) == 0)
        send_point(16'($urandom), 16'($urandom), i + 1 == n);
      else
        send_point(16'(cx + int'($urandom_range(0, spread)) - int'(spread / 2)),
                   16'(cy + int'($urandom_range(0, spread)) - int'(spread / 2)), i + 1 == n);
    end
  endtask

  task automatic test_extremes();
    write_reg(CfgEps, 36'd0);
    write_reg(CfgMin, 7'd1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b1);
    // single point set, all noise because eps is zero
    write_reg(CfgMin, 7'd2);
    send_point(16'sd0, 16'sd0, 1'b1);
    // widest radius and min_points zero: every point is core
    write_reg(CfgEps, 36'h8_0000_0000);
    write_reg(CfgMin, 7'd0);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sd5, -16'sd5, 1'b1);
  endtask

  task automatic test_strict_radius();
    // points exactly at the radius are not neighbors, one closer are
    write_reg(CfgEps, 36'd100);
    write_reg(CfgMin, 7'd2);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd10, 16'sd0, 1'b0);
    send_point(16'sd100, 16'sd0, 1'b0);
    send_point(16'sd109, 16'sd0, 1'b0);
    send_point(-16'sd500, 16'sd3, 1'b1);
    // min_points above the set size: all noise
    write_reg(CfgMin, 7'd64);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd1, 16'sd2, 1'b1);
  endtask

  task automatic test_border_point();
    // points chained within the radius all join one cluster
    write_reg(CfgEps, 36'd17);
    write_reg(CfgMin, 7'd3);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd4, 16'sd0, 1'b0);
    send_point(16'sd8, 16'sd0, 1'b0);
    send_point(16'sd7, 16'sd0, 1'b1);
  endtask

  task automatic test_capacity();
    // full set plus overflow points that get dropped, last one closes the set
    write_reg(CfgEps, 36'd5000);
    write_reg(CfgMin, 7'd4);
    send_cloud(NumSlots + 3, 60);
  endtask

  task automatic test_backpressure();
    // receiver stalls long enough that the next set waits at the input
    write_reg(CfgEps, 36'd40000);
    write_reg(CfgMin, 7'd2);
    hold_off = 20000;
    send_cloud(NumSlots, 300);
    send_cloud(10, 300);
  endtask

  task automatic test_random(int unsigned target);
    int unsigned sz;
    while (n_points < target) begin
      write_reg(CfgEps, ($urandom_range(0, 9) == 0) ? 36'($urandom) << $urandom_range(0, 4)
                                                     : 36'($urandom_range(0, 90000)));
      write_reg(CfgMin, 7'($urandom_range(1, 6)));
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 16);
      if (sz > target - n_points) sz = target - n_points;
      send_cloud(sz, $urandom_range(4, 600));
    end
  endtask

  // label checking and ready generation
  initial begin
    int unsigned wait_cnt;
    label_t got;
    label_t want;
    label_out.ready <= 1'b0;
    wait_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (label_out.valid && label_out.ready) begin
        got.point_index = label_out.point_index;
        got.cluster_id = label_out.cluster_id;
        got.is_noise = label_out.is_noise;
        got.last_label = label_out.last_label;
        n_labels++;
        if (expected_labels.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected label transaction %p", got);
        end else begin
          want = expected_labels.pop_front();
          if (got != want) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("label mismatch: expected %p, actual %p", want, got);
          end
        end
        wait_cnt = rx_gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) wait_cnt = 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        label_out.ready <= 1'b0;
      end else if (wait_cnt > 0) begin
        wait_cnt--;
        label_out.ready <= 1'b0;
      end else begin
        label_out.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((point_in.valid && point_in.ready) || (label_out.valid && label_out.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgEps;
    cfg_data_i = '0;
    point_in.valid = 1'b0;
    point_in.point_x = '0;
    point_in.point_y = '0;
    point_in.last_point = 1'b0;
    radius_sq = '0;
    core_count = 7'd2;
    n_stored = 0;
    n_mismatch = 0;
    n_labels = 0;
    n_points = 0;
    n_sets = 0;
    hold_off = 0;
    rx_gaps = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    rx_gaps = 1'b1;
    test_strict_radius();
    test_border_point();
    test_capacity();
    test_backpressure();
    test_random(190);
    rx_gaps = 1'b0;
    test_random(222);
    wait_drained();
    $display("covered %0d points in %0d sets, %0d labels checked", n_points, n_sets, n_labels);
    $display("radius and min_points swept incl. zero, widest and above set size");
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dc2d_pkg.sv
rtl/dc2d_if.sv
rtl/dc2d_dist.sv
rtl/density_cluster_2d_core.sv
dv/density_cluster_2d_core_tb.sv
